// ===== hw/rtl/lle_pkg.sv =====
package lle_pkg;

    // request codes
    localparam logic [2:0] REQ_UPLINK  = 3'd0;
    localparam logic [2:0] REQ_UA      = 3'd1;
    localparam logic [2:0] REQ_SABM    = 3'd2;
    localparam logic [2:0] REQ_RR      = 3'd3;
    localparam logic [2:0] REQ_PAYLOAD = 3'd4;

    // uplink report codes
    localparam logic [2:0] CODE_IGNORED   = 3'd0;
    localparam logic [2:0] CODE_EST_IND   = 3'd1;
    localparam logic [2:0] CODE_EST_CONF  = 3'd2;
    localparam logic [2:0] CODE_INFO_IND  = 3'd3;
    localparam logic [2:0] CODE_DL_ACK    = 3'd4;

    // link flag bit positions
    localparam int FLAG_EST   = 0;
    localparam int FLAG_AWAIT = 1;
    localparam int FLAG_SEG   = 2;
    localparam int FLAG_ACK   = 3;

    // frame octets
    localparam logic [7:0] PAD_BYTE  = 8'h2b;
    localparam logic [7:0] CTL_UA    = 8'h73;
    localparam logic [7:0] CTL_SABM  = 8'h3f;
    localparam logic [7:0] SABM_MASK = 8'hef;
    localparam logic [7:0] SABM_CODE = 8'h2f;
    localparam logic [7:0] LEN_EMPTY = 8'h01;
    localparam logic [3:0] RR_CODE   = 4'h1;

    // frame source for bytes past the header
    localparam logic [1:0] SRC_NONE    = 2'd0;
    localparam logic [1:0] SRC_LAYER3  = 2'd1;
    localparam logic [1:0] SRC_PAYLOAD = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_REPORT,
        ST_FRAME
    } t_state;

    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] link_sapi;
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
        logic       more_segments;
    } t_in_word;

    typedef struct packed {
        logic       is_downlink_frame;
        logic [2:0] uplink_code;
        logic [7:0] out_byte;
        logic       out_byte_valid;
        logic [2:0] out_sapi;
        logic       out_more_data;
        logic       out_acknowledged;
        logic [5:0] out_layer3_length;
        logic       out_last;
    } t_out_word;

    typedef struct packed {
        logic       accept;
        logic       judge;
        logic       load;
        logic       report;
        logic [5:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic go_judge;
        logic go_frame;
        logic out_free;
        logic item_last;
    } t_dp_stat;

endpackage

// ===== hw/rtl/lle_stream_if.sv =====
interface lle_stream_if #(
    parameter type T_WORD = logic
);
    logic  valid;
    logic  ready;
    T_WORD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lle_ctrl.sv =====
module lle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lle_pkg::t_dp_stat i_stat,
    output lle_pkg::t_dp_cmd  o_cmd
);
    lle_pkg::t_state r_state, n_state;
    logic [5:0]      r_idx, n_idx;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lle_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.idx    = r_idx;
        case (r_state)
            lle_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_idx      = '0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.go_judge) n_state = lle_pkg::ST_JUDGE;
                    else if (i_stat.go_frame) n_state = lle_pkg::ST_FRAME;
                end
            end
            lle_pkg::ST_JUDGE: begin
                o_cmd.judge = 1'b1;
                n_state     = lle_pkg::ST_REPORT;
            end
            lle_pkg::ST_REPORT: begin
                o_cmd.report = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_idx      = r_idx + 6'd1;
                    if (i_stat.item_last) n_state = lle_pkg::ST_IDLE;
                end
            end
            lle_pkg::ST_FRAME: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_idx      = r_idx + 6'd1;
                    if (i_stat.item_last) n_state = lle_pkg::ST_IDLE;
                end
            end
            default: n_state = lle_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/lle_dp.sv =====
module lle_dp #(
    parameter int LINKS       = 4,
    parameter int MAX_INFO    = 20,
    parameter int FRAME_BYTES = 23
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lle_pkg::t_in_word  i_word,
    input  logic               i_out_ready,
    output lle_pkg::t_out_word o_word,
    output logic               o_out_valid,
    input  lle_pkg::t_dp_cmd   i_cmd,
    output lle_pkg::t_dp_stat  o_stat
);
    localparam int LW  = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int UW  = $clog2(FRAME_BYTES);
    localparam int CW  = $clog2(FRAME_BYTES + 1);
    localparam int IW  = (MAX_INFO > 1) ? $clog2(MAX_INFO) : 1;
    localparam int PCW = $clog2(MAX_INFO + 2);
    localparam logic [7:0] ROOM = 8'(FRAME_BYTES - 3);
    localparam logic [7:0] MAXI = 8'(MAX_INFO);
    localparam logic [7:0] NLNK = 8'(LINKS);

    // stores
    logic [7:0]     r_up [FRAME_BYTES];
    logic [CW-1:0]  r_up_cnt;
    logic [7:0]     r_pay [MAX_INFO];
    logic [PCW-1:0] r_pay_cnt;
    logic [7:0]     r_l3 [MAX_INFO];
    logic [5:0]     r_l3_len;
    logic [2:0]     r_cur;
    logic           r_more;
    logic           r_acked;
    logic [2:0]     r_send [LINKS];
    logic [2:0]     r_recv [LINKS];
    logic [2:0]     r_pend [LINKS];
    logic [3:0]     r_flags [LINKS];

    // report and frame context
    logic [2:0]     r_rep_code;
    logic [5:0]     r_rep_n;
    logic [7:0]     r_h0, r_h1, r_h2;
    logic [1:0]     r_src;
    logic [5:0]     r_fn;

    logic               r_out_valid;
    lle_pkg::t_out_word r_out, n_out;

    // uplink judgement
    logic [7:0]    f0, f1, f2;
    logic [2:0]    j_sapi;
    logic [LW-1:0] j_idx;
    logic [5:0]    j_ilen;
    logic [7:0]    j_len8, j_need8;
    logic          j_len_ok, j_sapi_ok;
    logic [3:0]    j_flags;
    logic [2:0]    j_recv, j_pend;
    logic          j_rr, j_info, j_ack, j_took;
    logic [2:0]    j_code;
    logic          j_link;

    always_comb begin
        f0       = r_up[0];
        f1       = r_up[1];
        f2       = r_up[2];
        j_sapi   = f0[4:2];
        j_idx    = j_sapi[LW-1:0];
        j_ilen   = f2[7:2];
        j_len8   = 8'(r_up_cnt);
        j_need8  = 8'(j_ilen) + 8'd3;
        j_len_ok = (8'(j_ilen) <= MAXI) && (j_len8 >= j_need8);
        j_sapi_ok = 8'(j_sapi) < NLNK;
        j_flags  = j_sapi_ok ? r_flags[j_idx] : 4'd0;
        j_recv   = j_sapi_ok ? r_recv[j_idx] : 3'd0;
        j_pend   = j_sapi_ok ? r_pend[j_idx] : 3'd0;
        j_rr     = (f1[3:0] == lle_pkg::RR_CODE) && (f2 == lle_pkg::LEN_EMPTY);
        j_info   = !f1[0] && !f2[1] && j_len_ok;
        j_ack    = j_flags[lle_pkg::FLAG_ACK] && (f1[7:5] == j_pend);
        j_took   = 1'b0;
        j_link   = 1'b0;
        j_code   = lle_pkg::CODE_IGNORED;
        if ((j_len8 >= 8'd3) && f0[0] && f2[0] && j_sapi_ok) begin
            if ((f1 & lle_pkg::SABM_MASK) == lle_pkg::SABM_CODE) begin
                if (!f2[1] && (j_ilen != 6'd0) && j_len_ok && (j_sapi == 3'd0))
                    j_code = lle_pkg::CODE_EST_IND;
            end else if ((f1 == lle_pkg::CTL_UA) && (f2 == lle_pkg::LEN_EMPTY) &&
                         j_flags[lle_pkg::FLAG_AWAIT]) begin
                j_code = lle_pkg::CODE_EST_CONF;
            end else if (j_flags[lle_pkg::FLAG_EST] && (j_rr || j_info)) begin
                j_link = 1'b1;
                j_took = j_info && (f1[3:1] == j_recv);
                if (j_took) j_code = lle_pkg::CODE_INFO_IND;
                else if (j_ack) j_code = lle_pkg::CODE_DL_ACK;
            end
        end
    end

    // build request decode
    logic [2:0]     b_sapi;
    logic [LW-1:0]  b_idx;
    logic           b_sapi_ok;
    logic [3:0]     b_flags;
    logic [2:0]     b_send, b_recv;
    logic [PCW-1:0] b_pc;
    logic           b_store;
    logic           b_i_ok;
    logic [7:0]     b_ua_n;
    logic [7:0]     b_i_n;

    always_comb begin
        b_sapi    = i_word.link_sapi;
        b_idx     = b_sapi[LW-1:0];
        b_sapi_ok = 8'(b_sapi) < NLNK;
        b_flags   = b_sapi_ok ? r_flags[b_idx] : 4'd0;
        b_send    = b_sapi_ok ? r_send[b_idx] : 3'd0;
        b_recv    = b_sapi_ok ? r_recv[b_idx] : 3'd0;
        b_store   = i_word.byte_present && (8'(r_pay_cnt) <= MAXI);
        b_pc      = b_store ? r_pay_cnt + PCW'(1) : r_pay_cnt;
        b_i_ok    = b_sapi_ok && b_flags[lle_pkg::FLAG_EST] &&
                    !b_flags[lle_pkg::FLAG_ACK] && (8'(b_pc) <= MAXI);
        b_ua_n    = (8'(r_l3_len) < ROOM) ? 8'(r_l3_len) : ROOM;
        b_i_n     = (8'(b_pc) < ROOM) ? 8'(b_pc) : ROOM;
    end

    // status to controller
    logic [5:0] off;
    logic       rep_data;

    always_comb begin
        o_stat.go_judge = (i_word.req_type == lle_pkg::REQ_UPLINK) && i_word.last_byte;
        o_stat.go_frame = (i_word.req_type == lle_pkg::REQ_UA) ||
                          (i_word.req_type == lle_pkg::REQ_SABM) ||
                          (i_word.req_type == lle_pkg::REQ_RR) ||
                          ((i_word.req_type == lle_pkg::REQ_PAYLOAD) && i_word.last_byte);
        o_stat.out_free = !r_out_valid || i_out_ready;
        rep_data        = r_rep_n != 6'd0;
        if (i_cmd.report)
            o_stat.item_last = !rep_data || ((7'(i_cmd.idx) + 7'd1) == 7'(r_rep_n));
        else
            o_stat.item_last = i_cmd.idx == 6'(FRAME_BYTES - 1);
        off = i_cmd.idx - 6'd3;
    end

    // next result word
    always_comb begin
        n_out                   = '0;
        n_out.out_sapi          = r_cur;
        n_out.out_more_data     = r_more;
        n_out.out_acknowledged  = r_acked;
        n_out.out_layer3_length = r_l3_len;
        n_out.out_last          = o_stat.item_last;
        if (i_cmd.report) begin
            n_out.uplink_code    = r_rep_code;
            n_out.out_byte_valid = rep_data;
            n_out.out_byte       = rep_data ? r_up[UW'(i_cmd.idx + 6'd3)] : 8'd0;
        end else begin
            n_out.is_downlink_frame = 1'b1;
            n_out.out_byte_valid    = 1'b1;
            if (i_cmd.idx == 6'd0) n_out.out_byte = r_h0;
            else if (i_cmd.idx == 6'd1) n_out.out_byte = r_h1;
            else if (i_cmd.idx == 6'd2) n_out.out_byte = r_h2;
            else if (off < r_fn) begin
                if (r_src == lle_pkg::SRC_LAYER3) n_out.out_byte = r_l3[off[IW-1:0]];
                else if (r_src == lle_pkg::SRC_PAYLOAD) n_out.out_byte = r_pay[off[IW-1:0]];
                else n_out.out_byte = lle_pkg::PAD_BYTE;
            end else n_out.out_byte = lle_pkg::PAD_BYTE;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.load) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
        if (i_cmd.load) r_out <= n_out;
    end

    assign o_word      = r_out;
    assign o_out_valid = r_out_valid;

    // byte stores, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_word.req_type == lle_pkg::REQ_UPLINK) &&
            i_word.byte_present && (r_up_cnt < CW'(FRAME_BYTES)))
            r_up[r_up_cnt[UW-1:0]] <= i_word.data_byte;
        if (i_cmd.accept && (i_word.req_type == lle_pkg::REQ_PAYLOAD) && b_store &&
            (8'(r_pay_cnt) < MAXI))
            r_pay[r_pay_cnt[IW-1:0]] <= i_word.data_byte;
        if (i_cmd.load && i_cmd.report && rep_data)
            r_l3[i_cmd.idx[IW-1:0]] <= r_up[UW'(i_cmd.idx + 6'd3)];
    end

    // frame header and report capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_h0  <= lle_pkg::PAD_BYTE;
            r_h1  <= lle_pkg::PAD_BYTE;
            r_h2  <= lle_pkg::PAD_BYTE;
            r_src <= lle_pkg::SRC_NONE;
            r_fn  <= 6'd0;
            case (i_word.req_type)
                lle_pkg::REQ_UA: begin
                    r_h0  <= {3'd0, r_cur, 2'b01};
                    r_h1  <= lle_pkg::CTL_UA;
                    r_h2  <= {r_l3_len, 2'b01};
                    r_src <= lle_pkg::SRC_LAYER3;
                    r_fn  <= b_ua_n[5:0];
                end
                lle_pkg::REQ_SABM: begin
                    if (b_sapi_ok) begin
                        r_h0 <= {3'd0, b_sapi, 2'b11};
                        r_h1 <= lle_pkg::CTL_SABM;
                        r_h2 <= lle_pkg::LEN_EMPTY;
                    end
                end
                lle_pkg::REQ_RR: begin
                    if (b_sapi_ok && b_flags[lle_pkg::FLAG_EST]) begin
                        r_h0 <= {3'd0, b_sapi, 2'b01};
                        r_h1 <= {b_recv, 5'b00001};
                        r_h2 <= lle_pkg::LEN_EMPTY;
                    end
                end
                lle_pkg::REQ_PAYLOAD: begin
                    if (b_i_ok) begin
                        r_h0  <= {3'd0, b_sapi, 2'b11};
                        r_h1  <= {b_recv, 1'b0, b_send, 1'b0};
                        r_h2  <= {6'(b_pc), i_word.more_segments, 1'b1};
                        r_src <= lle_pkg::SRC_PAYLOAD;
                        r_fn  <= b_i_n[5:0];
                    end
                end
                default: r_src <= lle_pkg::SRC_NONE;
            endcase
        end
        if (i_cmd.judge) begin
            r_rep_code <= j_code;
            r_rep_n    <= ((j_code == lle_pkg::CODE_EST_IND) ||
                           (j_code == lle_pkg::CODE_INFO_IND)) ? j_ilen : 6'd0;
        end
    end

    // link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_cnt  <= '0;
            r_pay_cnt <= '0;
            r_l3_len  <= '0;
            r_cur     <= '0;
            r_more    <= 1'b0;
            r_acked   <= 1'b0;
            for (int s = 0; s < LINKS; s++) begin
                r_send[s]  <= '0;
                r_recv[s]  <= '0;
                r_pend[s]  <= '0;
                r_flags[s] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                case (i_word.req_type)
                    lle_pkg::REQ_UPLINK: begin
                        if (i_word.byte_present && (r_up_cnt < CW'(FRAME_BYTES)))
                            r_up_cnt <= r_up_cnt + CW'(1);
                    end
                    lle_pkg::REQ_UA: begin
                        if (8'(r_cur) < NLNK) begin
                            r_flags[r_cur[LW-1:0]][lle_pkg::FLAG_EST] <= 1'b1;
                            r_flags[r_cur[LW-1:0]][lle_pkg::FLAG_SEG] <= 1'b0;
                            r_flags[r_cur[LW-1:0]][lle_pkg::FLAG_ACK] <= 1'b0;
                        end
                    end
                    lle_pkg::REQ_SABM: begin
                        if (b_sapi_ok) begin
                            r_send[b_idx]  <= '0;
                            r_recv[b_idx]  <= '0;
                            r_pend[b_idx]  <= '0;
                            r_flags[b_idx] <= 4'(1 << lle_pkg::FLAG_AWAIT);
                        end
                    end
                    lle_pkg::REQ_PAYLOAD: begin
                        r_pay_cnt <= i_word.last_byte ? '0 : b_pc;
                        if (i_word.last_byte && b_i_ok) begin
                            r_send[b_idx] <= b_send + 3'd1;
                            r_pend[b_idx] <= b_send + 3'd1;
                            r_flags[b_idx][lle_pkg::FLAG_SEG] <= i_word.more_segments;
                            r_flags[b_idx][lle_pkg::FLAG_ACK] <= 1'b1;
                        end
                    end
                    default: r_cur <= r_cur;
                endcase
            end
            if (i_cmd.judge) begin
                r_up_cnt <= '0;
                r_acked  <= j_link && j_ack;
                case (j_code)
                    lle_pkg::CODE_EST_IND: begin
                        r_cur          <= j_sapi;
                        r_l3_len       <= j_ilen;
                        r_more         <= 1'b0;
                        r_send[j_idx]  <= '0;
                        r_recv[j_idx]  <= '0;
                        r_pend[j_idx]  <= '0;
                        r_flags[j_idx] <= '0;
                    end
                    lle_pkg::CODE_EST_CONF: begin
                        r_cur <= j_sapi;
                        r_flags[j_idx][lle_pkg::FLAG_EST]   <= 1'b1;
                        r_flags[j_idx][lle_pkg::FLAG_AWAIT] <= 1'b0;
                    end
                    default: begin
                        if (j_took) begin
                            r_cur         <= j_sapi;
                            r_l3_len      <= j_ilen;
                            r_more        <= f2[1];
                            r_recv[j_idx] <= j_recv + 3'd1;
                        end
                        if (j_link && j_ack) begin
                            r_cur <= j_sapi;
                            r_flags[j_idx][lle_pkg::FLAG_ACK] <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end
endmodule

// ===== hw/rtl/lapdm_link_layer_engine_core.sv =====
// Channel   Dir  Word               Accepted when
// i_in      in   lle_pkg::t_in_word  i_in.valid && i_in.ready
// o_out     out  lle_pkg::t_out_word o_out.valid && o_out.ready
//
// Stored bytes (uplink bytes and payload bytes not marked last) are taken in the idle state.
// An uplink frame end passes through a judge state, then gives 1 to MAX_INFO report words.
// A build request emits FRAME_BYTES words, one per cycle while o_out is ready.
// Input is held off while a report or frame is being emitted; the output
// register lets the last word wait while the next input word is taken.
// Synchronous active-low reset clears all link state; no clearing pass.
module lapdm_link_layer_engine_core #(
    parameter int LINKS       = 4,
    parameter int MAX_INFO    = 20,
    parameter int FRAME_BYTES = 23
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lle_stream_if.sink   i_in,
    lle_stream_if.source o_out
);
    lle_pkg::t_dp_cmd  cmd;
    lle_pkg::t_dp_stat stat;

    lle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lle_dp #(
        .LINKS       (LINKS),
        .MAX_INFO    (MAX_INFO),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_in.data),
        .i_out_ready (o_out.ready),
        .o_word      (o_out.data),
        .o_out_valid (o_out.valid),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );
endmodule

// ===== verif/lapdm_link_layer_engine_core_tb.sv =====
`timescale 1ns / 1ps

module lapdm_link_layer_engine_core_tb;

    localparam int LINKS       = 4;
    localparam int MAX_INFO    = 20;
    localparam int FRAME_BYTES = 23;
    localparam int IDLE_LIMIT  = 3000;
    localparam int ITEM_GOAL   = 430;
    localparam int TAIL_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    lle_stream_if #(.T_WORD(lle_pkg::t_in_word))  in_if ();
    lle_stream_if #(.T_WORD(lle_pkg::t_out_word)) out_if ();

    lapdm_link_layer_engine_core #(
        .LINKS       (LINKS),
        .MAX_INFO    (MAX_INFO),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // link state mirror
    // ------------------------------------------------------------------
    logic [7:0] up_buf [FRAME_BYTES];
    int         up_cnt;
    logic [7:0] pay_buf [MAX_INFO];
    int         pay_cnt;
    logic [7:0] l3_buf [MAX_INFO];
    int         l3_len;
    logic [2:0] cur_link;
    logic       l3_more;
    logic       acked;
    logic [2:0] vs [LINKS];
    logic [2:0] vr [LINKS];
    logic [2:0] va [LINKS];
    logic [3:0] flags [LINKS];

    lle_pkg::t_out_word pending_out_words [$];
    int                 mismatches = 0;
    int                 n_items;
    bit                 drained = 1'b0;

    function automatic void push_word(logic dl, logic [2:0] code, logic [7:0] b, logic v,
                                      logic last);
        lle_pkg::t_out_word o;
        o.is_downlink_frame = dl;
        o.uplink_code       = code;
        o.out_byte          = b;
        o.out_byte_valid    = v;
        o.out_sapi          = cur_link;
        o.out_more_data     = l3_more;
        o.out_acknowledged  = acked;
        o.out_layer3_length = l3_len[5:0];
        o.out_last          = last;
        pending_out_words.push_back(o);
    endfunction

    function automatic void push_frame(logic [7:0] f [FRAME_BYTES]);
        for (int i = 0; i < FRAME_BYTES; i++)
            push_word(1'b1, lle_pkg::CODE_IGNORED, f[i], 1'b1, i == FRAME_BYTES - 1);
    endfunction

    function automatic void reset_link(int s);
        vs[s] = '0;
        vr[s] = '0;
        va[s] = '0;
        flags[s] = '0;
    endfunction

    function automatic void store_layer3(int n, logic more);
        for (int i = 0; i < MAX_INFO; i++)
            l3_buf[i] = (i < n) ? up_buf[3 + i] : 8'h00;
        l3_len  = n;
        l3_more = more;
    endfunction

    // check a finished uplink frame, return the report code
    function automatic logic [2:0] judge_frame();
        int         len;
        int         s;
        int         ilen;
        logic [7:0] ctl;
        logic [7:0] lb;
        logic       rr;
        logic       info;
        logic       ack;
        logic       took;
        len   = up_cnt;
        took  = 1'b0;
        acked = 1'b0;
        if (len < 3 || !up_buf[0][0] || !up_buf[2][0])
            return lle_pkg::CODE_IGNORED;
        s    = up_buf[0][4:2];
        ctl  = up_buf[1];
        lb   = up_buf[2];
        ilen = lb[7:2];
        if (s >= LINKS)
            return lle_pkg::CODE_IGNORED;
        // SABM, SAPI 0 only
        if ((ctl & lle_pkg::SABM_MASK) == lle_pkg::SABM_CODE) begin
            if (lb[1] || ilen == 0 || ilen > MAX_INFO || len < 3 + ilen || s != 0)
                return lle_pkg::CODE_IGNORED;
            cur_link = 3'(s);
            store_layer3(ilen, 1'b0);
            reset_link(s);
            return lle_pkg::CODE_EST_IND;
        end
        // UA answering our SABM
        if (ctl == lle_pkg::CTL_UA && lb == lle_pkg::LEN_EMPTY &&
                flags[s][lle_pkg::FLAG_AWAIT]) begin
            cur_link = 3'(s);
            flags[s][lle_pkg::FLAG_EST]   = 1'b1;
            flags[s][lle_pkg::FLAG_AWAIT] = 1'b0;
            return lle_pkg::CODE_EST_CONF;
        end
        if (!flags[s][lle_pkg::FLAG_EST])
            return lle_pkg::CODE_IGNORED;
        rr   = ctl[3:0] == lle_pkg::RR_CODE && lb == lle_pkg::LEN_EMPTY;
        info = !ctl[0] && !lb[1] && ilen <= MAX_INFO && len >= 3 + ilen;
        if (!rr && !info)
            return lle_pkg::CODE_IGNORED;
        ack = flags[s][lle_pkg::FLAG_ACK] && ctl[7:5] == va[s];
        if (info && ctl[3:1] == vr[s]) begin
            cur_link = 3'(s);
            store_layer3(ilen, lb[1]);
            vr[s] = vr[s] + 3'd1;
            took = 1'b1;
        end
        if (ack) begin
            cur_link = 3'(s);
            flags[s][lle_pkg::FLAG_ACK] = 1'b0;
            acked = 1'b1;
        end
        if (took)
            return lle_pkg::CODE_INFO_IND;
        return ack ? lle_pkg::CODE_DL_ACK : lle_pkg::CODE_IGNORED;
    endfunction

    // expected words for one accepted input word
    function automatic void lapdm_predict(lle_pkg::t_in_word w);
        logic [7:0] f [FRAME_BYTES];
        logic [2:0] code;
        int         s;
        s = w.link_sapi;
        for (int i = 0; i < FRAME_BYTES; i++)
            f[i] = lle_pkg::PAD_BYTE;
        case (w.req_type)
            lle_pkg::REQ_UPLINK: begin
                if (w.byte_present && up_cnt < FRAME_BYTES) begin
                    up_buf[up_cnt] = w.data_byte;
                    up_cnt++;
                end
                if (w.last_byte) begin
                    code = judge_frame();
                    up_cnt = 0;
                    if ((code == lle_pkg::CODE_EST_IND || code == lle_pkg::CODE_INFO_IND)
                            && l3_len > 0) begin
                        for (int i = 0; i < l3_len; i++)
                            push_word(1'b0, code, l3_buf[i], 1'b1, i + 1 == l3_len);
                    end else begin
                        push_word(1'b0, code, 8'h00, 1'b0, 1'b1);
                    end
                end
            end
            lle_pkg::REQ_UA: begin
                f[0] = {3'b000, cur_link, 2'b01};
                f[1] = lle_pkg::CTL_UA;
                f[2] = {l3_len[5:0], 2'b01};
                for (int i = 0; i < l3_len; i++)
                    f[3 + i] = l3_buf[i];
                if (cur_link < LINKS) begin
                    flags[cur_link][lle_pkg::FLAG_EST] = 1'b1;
                    flags[cur_link][lle_pkg::FLAG_SEG] = 1'b0;
                    flags[cur_link][lle_pkg::FLAG_ACK] = 1'b0;
                end
                push_frame(f);
            end
            lle_pkg::REQ_SABM: begin
                if (s < LINKS) begin
                    reset_link(s);
                    flags[s][lle_pkg::FLAG_AWAIT] = 1'b1;
                    f[0] = {3'b000, w.link_sapi, 2'b11};
                    f[1] = lle_pkg::CTL_SABM;
                    f[2] = lle_pkg::LEN_EMPTY;
                end
                push_frame(f);
            end
            lle_pkg::REQ_RR: begin
                if (s < LINKS && flags[s][lle_pkg::FLAG_EST]) begin
                    f[0] = {3'b000, w.link_sapi, 2'b01};
                    f[1] = {vr[s], 5'b00001};
                    f[2] = lle_pkg::LEN_EMPTY;
                end
                push_frame(f);
            end
            lle_pkg::REQ_PAYLOAD: begin
                if (w.byte_present && pay_cnt <= MAX_INFO) begin
                    if (pay_cnt < MAX_INFO)
                        pay_buf[pay_cnt] = w.data_byte;
                    pay_cnt++;
                end
                if (w.last_byte) begin
                    if (s < LINKS && flags[s][lle_pkg::FLAG_EST] &&
                            !flags[s][lle_pkg::FLAG_ACK] && pay_cnt <= MAX_INFO) begin
                        f[0] = {3'b000, w.link_sapi, 2'b11};
                        f[1] = {vr[s], 1'b0, vs[s], 1'b0};
                        f[2] = {pay_cnt[5:0], w.more_segments, 1'b1};
                        for (int i = 0; i < pay_cnt; i++)
                            f[3 + i] = pay_buf[i];
                        vs[s] = vs[s] + 3'd1;
                        va[s] = vs[s];
                        flags[s][lle_pkg::FLAG_SEG] = w.more_segments;
                        flags[s][lle_pkg::FLAG_ACK] = 1'b1;
                    end
                    pay_cnt = 0;
                    push_frame(f);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    int burst_left;

    task automatic send_word(lle_pkg::t_in_word w);
        int gap;
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        in_if.data  <= w;
        in_if.valid <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        lapdm_predict(w);
        n_items++;
    endtask

    task automatic send_req(logic [2:0] req, logic [2:0] sapi, logic [7:0] b, logic present,
                            logic last, logic more);
        lle_pkg::t_in_word w;
        w.req_type      = req;
        w.link_sapi     = sapi;
        w.data_byte     = b;
        w.byte_present  = present;
        w.last_byte     = last;
        w.more_segments = more;
        send_word(w);
    endtask

    // uplink frame, with the odd absent byte mixed in
    task automatic send_uplink(logic [7:0] bytes [$]);
        for (int i = 0; i < bytes.size(); i++) begin
            if ($urandom_range(0, 19) == 0)
                send_req(lle_pkg::REQ_UPLINK, 3'($urandom), 8'($urandom), 1'b0, 1'b0,
                         1'($urandom));
            send_req(lle_pkg::REQ_UPLINK, 3'($urandom), bytes[i], 1'b1,
                     i == bytes.size() - 1, 1'($urandom));
        end
    endtask

    task automatic send_payload(logic [2:0] sapi, int n, logic more);
        for (int i = 0; i < n; i++)
            send_req(lle_pkg::REQ_PAYLOAD, sapi, 8'($urandom), 1'b1, i == n - 1, more);
        if (n == 0)
            send_req(lle_pkg::REQ_PAYLOAD, sapi, 8'($urandom), 1'b0, 1'b1, more);
    endtask

    task automatic pause_until_drained();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_out_words.size() != 0) @(posedge i_clk);
    endtask

    // one random sequence, mostly well formed
    task automatic send_random_seq();
        logic [7:0] fr [$];
        int         s;
        int         n;
        logic [2:0] nr;
        logic [2:0] ns;
        logic       m;
        s = $urandom_range(0, LINKS - 1);
        m = 1'($urandom);
        case ($urandom_range(0, 11))
            0: begin    // peer SABM
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 22) : $urandom_range(1, 5);
                fr.push_back(($urandom_range(0, 3) == 0)
                             ? {3'b000, 3'($urandom_range(0, 7)), 2'b01} : 8'h01);
                fr.push_back($urandom_range(0, 1) ? lle_pkg::CTL_SABM : lle_pkg::SABM_CODE);
                fr.push_back({n[5:0], ($urandom_range(0, 7) == 0), 1'b1});
                repeat ($urandom_range(0, 4) == 0 ? $urandom_range(0, 22) : n)
                    fr.push_back(8'($urandom));
                send_uplink(fr);
            end
            1: send_req(lle_pkg::REQ_UA, 3'($urandom), 8'($urandom), 1'($urandom),
                        1'($urandom), 1'($urandom));
            2, 3: begin    // our SABM and the peer's UA
                s = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : s;
                send_req(lle_pkg::REQ_SABM, 3'(s), 8'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom));
                fr.push_back({s[5:0], 2'b01});
                fr.push_back(lle_pkg::CTL_UA);
                fr.push_back(lle_pkg::LEN_EMPTY);
                send_uplink(fr);
            end
            4, 5: begin    // peer I frame
                n  = $urandom_range(0, 3) == 0 ? $urandom_range(0, MAX_INFO) : $urandom_range(0, 6);
                ns = ($urandom_range(0, 4) == 0) ? 3'($urandom) : vr[s];
                nr = ($urandom_range(0, 2) == 0) ? 3'($urandom) : va[s];
                fr.push_back({s[5:0], 2'b01});
                fr.push_back({nr, ns, 1'b0});
                fr.push_back({n[5:0], m, 1'b1});
                repeat (n) fr.push_back(8'($urandom));
                send_uplink(fr);
            end
            6: begin    // peer RR
                nr = ($urandom_range(0, 2) == 0) ? 3'($urandom) : va[s];
                fr.push_back({s[5:0], 2'b01});
                fr.push_back({nr, 1'($urandom_range(0, 1)), 4'h1});
                fr.push_back(lle_pkg::LEN_EMPTY);
                send_uplink(fr);
            end
            7, 8: begin    // downlink I frame, overlength now and then
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_INFO - 1, 24)
                                                : $urandom_range(0, 8);
                send_payload(($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'(s), n, m);
            end
            9: send_req(lle_pkg::REQ_RR, ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'(s),
                        8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            10: begin    // noise frame, may overflow
                repeat ($urandom_range(1, 28)) fr.push_back(8'($urandom));
                send_uplink(fr);
            end
            default: send_req(3'($urandom_range(5, 7)), 3'($urandom), 8'($urandom),
                              1'($urandom), 1'($urandom), 1'($urandom));
        endcase
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef struct {
        lle_pkg::t_in_word  w;
        logic               typed;
        lle_pkg::t_out_word want;
    } t_row;

    function automatic t_row row(logic [2:0] req, logic [2:0] sapi, logic [7:0] b,
                                 logic present, logic last, logic more);
        t_row r;
        r.w     = '{req, sapi, b, present, last, more};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_row row_typed(logic [2:0] req, logic [7:0] b, logic [2:0] code,
                                       logic [2:0] sapi_out);
        t_row r;
        r = row(req, 3'd7, b, 1'b1, 1'b1, 1'b1);
        r.typed = 1'b1;
        r.want  = '{1'b0, code, 8'h00, 1'b0, sapi_out, 1'b0, 1'b0, 6'd0, 1'b1};
        return r;
    endfunction

    t_row dir_rows [$];

    initial begin
        dir_rows = '{
            // lone byte after reset: too short to judge
            row_typed(lle_pkg::REQ_UPLINK, 8'h00, lle_pkg::CODE_IGNORED, 3'd0),
            row(3'd5, 3'd0, 8'hff, 1'b1, 1'b1, 1'b1),
            row(3'd7, 3'd7, 8'h00, 1'b0, 1'b0, 1'b0),
            // builds that fail their guard give padding only
            row(lle_pkg::REQ_RR, 3'd0, 8'h00, 1'b0, 1'b0, 1'b0),
            row(lle_pkg::REQ_SABM, 3'd7, 8'hff, 1'b1, 1'b1, 1'b1),
            // establish SAPI 1 from our side
            row(lle_pkg::REQ_SABM, 3'd1, 8'h00, 1'b0, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'h05, 1'b1, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, lle_pkg::CTL_UA, 1'b1, 1'b0, 1'b0),
            row_typed(lle_pkg::REQ_UPLINK, lle_pkg::LEN_EMPTY, lle_pkg::CODE_EST_CONF, 3'd1),
            // I frame with one real byte and one absent byte
            row(lle_pkg::REQ_PAYLOAD, 3'd1, 8'hff, 1'b1, 1'b0, 1'b1),
            row(lle_pkg::REQ_PAYLOAD, 3'd1, 8'h00, 1'b0, 1'b1, 1'b1),
            // peer RR acks it
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'h05, 1'b1, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'h21, 1'b1, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, lle_pkg::LEN_EMPTY, 1'b1, 1'b1, 1'b0),
            // peer SABM on SAPI 0 with one layer-3 byte
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'h01, 1'b1, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, lle_pkg::SABM_CODE, 1'b1, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'h05, 1'b1, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'ha5, 1'b1, 1'b1, 1'b0),
            row(lle_pkg::REQ_UA, 3'd5, 8'h00, 1'b0, 1'b0, 1'b0),
            // peer I frame with M set
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'h01, 1'b1, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'h00, 1'b1, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'h07, 1'b1, 1'b0, 1'b0),
            row(lle_pkg::REQ_UPLINK, 3'd0, 8'h80, 1'b1, 1'b1, 1'b0),
            row(lle_pkg::REQ_RR, 3'd4, 8'h00, 1'b0, 1'b0, 1'b0),
            row(lle_pkg::REQ_RR, 3'd0, 8'h00, 1'b0, 1'b0, 1'b0)
        };
    end

    // ------------------------------------------------------------------
    // receiver stall pattern
    // ------------------------------------------------------------------
    int unsigned rx_cyc = 0;
    int unsigned rx_mode = 0;

    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc % 300 == 0)
            rx_mode <= $urandom_range(0, 4);
        case (rx_mode)
            0, 1:    out_if.ready <= 1'b1;
            2:       out_if.ready <= (rx_cyc % 4) != 0;
            3:       out_if.ready <= (rx_cyc % 7) < 2;
            default: out_if.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // ------------------------------------------------------------------
    // output check and watchdog
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        lle_pkg::t_out_word exp_w;
        lle_pkg::t_out_word got;
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (pending_out_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", got);
            end else begin
                exp_w = pending_out_words.pop_front();
                if (got !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: dl %0d/%0d code %0d/%0d byte %h/%h vld %0d/%0d ",
                                  "sapi %0d/%0d more %0d/%0d ack %0d/%0d len %0d/%0d ",
                                  "last %0d/%0d (exp/got)"},
                                 exp_w.is_downlink_frame, got.is_downlink_frame,
                                 exp_w.uplink_code, got.uplink_code,
                                 exp_w.out_byte, got.out_byte,
                                 exp_w.out_byte_valid, got.out_byte_valid,
                                 exp_w.out_sapi, got.out_sapi,
                                 exp_w.out_more_data, got.out_more_data,
                                 exp_w.out_acknowledged, got.out_acknowledged,
                                 exp_w.out_layer3_length, got.out_layer3_length,
                                 exp_w.out_last, got.out_last);
                end
            end
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        i_rst_n      <= 1'b0;
        n_items      = 0;
        burst_left   = 0;
        up_cnt       = 0;
        pay_cnt      = 0;
        l3_len       = 0;
        cur_link     = '0;
        l3_more      = 1'b0;
        acked        = 1'b0;
        for (int s = 0; s < LINKS; s++)
            reset_link(s);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; typed rows replace the predicted single report
        foreach (dir_rows[k]) begin
            send_word(dir_rows[k].w);
            if (dir_rows[k].typed) begin
                void'(pending_out_words.pop_back());
                pending_out_words.push_back(dir_rows[k].want);
            end
        end

        // random sequences, one full drain half way
        while (n_items < ITEM_GOAL) begin
            send_random_seq();
            if (!drained && n_items >= ITEM_GOAL / 2) begin
                pause_until_drained();
                drained = 1'b1;
            end
        end

        in_if.valid <= 1'b0;
        while (pending_out_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_out_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lle_pkg.sv
hw/rtl/lle_stream_if.sv
hw/rtl/lle_ctrl.sv
hw/rtl/lle_dp.sv
hw/rtl/lapdm_link_layer_engine_core.sv
verif/lapdm_link_layer_engine_core_tb.sv
